// File: hw/rtl/zfs_pkg.sv
// Shared types for the frame size scanner: field widths, status codes, the input
// item, the result item and the bundle of results that one input can produce.
// No dependencies.
`timescale 1ns / 1ps

package zfs_pkg;

    localparam int FSIZE_W   = 48;
    localparam int CSIZE_W   = 64;
    localparam int DICT_W    = 32;
    localparam int STATUS_W  = 4;
    localparam int RQ_DEPTH  = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 4'd0,
        ST_BAD_MAGIC      = 4'd1,
        ST_RESERVED_BIT   = 4'd2,
        ST_WINDOW_LOG     = 4'd3,
        ST_RESERVED_BLOCK = 4'd4,
        ST_SKIP_OVERFLOW  = 4'd5,
        ST_TRUNCATED      = 4'd6,
        ST_SIZE_UNKNOWN   = 4'd7,
        ST_NONE_FOUND     = 4'd8,
        ST_COUNTER_OVF    = 4'd9
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_of_stream;
    } t_item;

    typedef struct packed {
        logic                result_kind;
        logic [FSIZE_W-1:0]  frame_size;
        logic                frame_skippable;
        logic [DICT_W-1:0]   dictionary_id;
        logic [CSIZE_W-1:0]  content_size;
        logic                content_known;
        logic [FSIZE_W-1:0]  largest_frame_size;
        logic [CSIZE_W-1:0]  largest_content_size;
        logic [STATUS_W-1:0] status;
        logic                last_result;
    } t_result;

    // Results produced by one input item, in delivery order.
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_emit;

endpackage

// File: hw/rtl/zfs_in_if.sv
// Input byte channel of the frame size scanner.
// No dependencies.
`timescale 1ns / 1ps

interface zfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_of_stream;

    modport source (output valid, output data_byte, output has_byte,
                    output last_of_stream, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input last_of_stream, output ready);
endinterface

// File: hw/rtl/zfs_out_if.sv
// Result channel of the frame size scanner.
// Depends on zfs_pkg.
`timescale 1ns / 1ps

interface zfs_out_if;
    import zfs_pkg::*;

    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [FSIZE_W-1:0]  frame_size;
    logic                frame_skippable;
    logic [DICT_W-1:0]   dictionary_id;
    logic [CSIZE_W-1:0]  content_size;
    logic                content_known;
    logic [FSIZE_W-1:0]  largest_frame_size;
    logic [CSIZE_W-1:0]  largest_content_size;
    logic [STATUS_W-1:0] status;
    logic                last_result;

    modport source (output valid, output result_kind, output frame_size,
                    output frame_skippable, output dictionary_id,
                    output content_size, output content_known,
                    output largest_frame_size, output largest_content_size,
                    output status, output last_result, input ready);
    modport sink   (input valid, input result_kind, input frame_size,
                    input frame_skippable, input dictionary_id,
                    input content_size, input content_known,
                    input largest_frame_size, input largest_content_size,
                    input status, input last_result, output ready);
endinterface

// File: hw/rtl/zfs_cfg_if.sv
// Configuration write channel of the frame size scanner.
// No dependencies.
`timescale 1ns / 1ps

interface zfs_cfg_if;
    logic valid;
    logic ready;
    logic content_mode;

    modport source (output valid, output content_mode, input ready);
    modport sink   (input valid, input content_mode, output ready);
endinterface

// File: hw/rtl/zfs_parser.sv
// Header parser: holds the stream state and advances it by one input item
// per enabled cycle, producing up to two results.
// Depends on zfs_pkg.
`timescale 1ns / 1ps

module zfs_parser #(
    parameter int FRAME_SIZE_BITS = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  zfs_pkg::t_item i_item,
    input  logic           i_mode,
    output zfs_pkg::t_emit o_emit
);
    import zfs_pkg::*;

    localparam logic [31:0] MAGIC_REGULAR   = 32'hFD2FB528;
    localparam logic [31:0] MAGIC_SKIP      = 32'h184D2A50;
    localparam logic [31:0] MAGIC_SKIP_MASK = 32'hFFFFFFF0;
    localparam logic [31:0] SKIP_LEN_MAX    = 32'hFFFFFFF7;
    localparam logic [7:0]  WLOG_BASE       = 8'd10;
    localparam logic [7:0]  WLOG_MAX        = 8'd31;
    localparam logic [7:0]  DESC_RESERVED   = 8'h08;
    localparam logic [CSIZE_W-1:0] FCS_OFFSET = CSIZE_W'(256);
    localparam logic [31:0] CHECKSUM_LEN    = 32'd4;
    localparam logic [1:0]  BT_RLE          = 2'd1;
    localparam logic [1:0]  BT_FORBIDDEN    = 2'd3;
    localparam logic [3:0]  DICT_LEN_TAB [4] = '{4'd0, 4'd1, 4'd2, 4'd4};
    localparam logic [3:0]  FCS_LEN_TAB  [4] = '{4'd0, 4'd2, 4'd4, 4'd8};

    typedef enum logic [10:0] {
        PH_MAGIC    = 11'b000_0000_0001,
        PH_SKIPLEN  = 11'b000_0000_0010,
        PH_SKIPBODY = 11'b000_0000_0100,
        PH_DESC     = 11'b000_0000_1000,
        PH_WINDOW   = 11'b000_0001_0000,
        PH_DICT     = 11'b000_0010_0000,
        PH_FCS      = 11'b000_0100_0000,
        PH_BLKHDR   = 11'b000_1000_0000,
        PH_BLKBODY  = 11'b001_0000_0000,
        PH_CHECKSUM = 11'b010_0000_0000,
        PH_ERROR    = 11'b100_0000_0000
    } t_phase;

    function automatic logic [3:0] fcs_len(input logic [7:0] d);
        if (d[7:6] == 2'd0) begin
            return d[5] ? 4'd1 : 4'd0;
        end
        return FCS_LEN_TAB[d[7:6]];
    endfunction

    // Phase that follows the dictionary field (or its absence).
    function automatic t_phase after_dict(input logic [7:0] d);
        return (fcs_len(d) != 4'd0) ? PH_FCS : PH_BLKHDR;
    endfunction

    // Phase that follows the descriptor and optional window byte.
    function automatic t_phase after_desc(input logic [7:0] d);
        return (d[1:0] != 2'd0) ? PH_DICT : after_dict(d);
    endfunction

    t_phase                     r_phase, n_phase;
    logic [3:0]                 r_idx, n_idx;
    logic [63:0]                r_acc, n_acc;
    logic [7:0]                 r_desc, n_desc;
    logic [31:0]                r_skip, n_skip;
    logic [FRAME_SIZE_BITS-1:0] r_count, n_count;
    logic [CSIZE_W-1:0]         r_csize, n_csize;
    logic [DICT_W-1:0]          r_dict, n_dict;
    logic                       r_skippable, n_skippable;
    logic                       r_last_blk, n_last_blk;
    logic [FRAME_SIZE_BITS-1:0] r_lf, n_lf;
    logic [CSIZE_W-1:0]         r_lc, n_lc;
    t_status                    r_err, n_err;

    t_emit emit;

    always_comb begin
        logic [63:0]                g_acc;
        logic [3:0]                 g_idx;
        logic [FRAME_SIZE_BITS-1:0] cnt_inc;
        logic [23:0]                blk_hdr;
        logic [31:0]                blk_size;
        logic                       fin;
        logic                       blk_done;
        logic                       known;
        logic                       best_zero;
        t_status                    st;
        t_result                    res_frame;
        t_result                    res_sum;

        n_phase     = r_phase;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_desc      = r_desc;
        n_skip      = r_skip;
        n_count     = r_count;
        n_csize     = r_csize;
        n_dict      = r_dict;
        n_skippable = r_skippable;
        n_last_blk  = r_last_blk;
        n_lf        = r_lf;
        n_lc        = r_lc;
        n_err       = r_err;

        g_acc    = r_acc | (64'(i_item.data_byte) << {r_idx[2:0], 3'b000});
        g_idx    = r_idx + 4'd1;
        cnt_inc  = r_count + FRAME_SIZE_BITS'(1);
        blk_hdr  = g_acc[23:0];
        blk_size = (blk_hdr[2:1] == BT_RLE) ? 32'd1 : 32'(blk_hdr[23:3]);
        fin      = 1'b0;
        blk_done = 1'b0;
        known    = (r_csize != '1);
        emit     = '0;

        res_frame                 = '0;
        res_frame.result_kind     = 1'b0;
        res_frame.frame_size      = FSIZE_W'(cnt_inc);
        res_frame.frame_skippable = r_skippable;
        res_frame.dictionary_id   = r_dict;
        res_frame.content_size    = r_skippable ? '0 : r_csize;
        res_frame.content_known   = !r_skippable && known;
        res_frame.last_result     = !i_item.last_of_stream;

        if (i_take && i_item.has_byte && r_phase != PH_ERROR) begin
            if (&r_count) begin
                n_err   = ST_COUNTER_OVF;
                n_phase = PH_ERROR;
            end else begin
                n_count = cnt_inc;
                unique case (r_phase)
                    PH_MAGIC: begin
                        n_acc = g_acc;
                        n_idx = g_idx;
                        if (g_idx == 4'd4) begin
                            if (g_acc[31:0] == MAGIC_REGULAR) begin
                                n_phase = PH_DESC;
                                n_idx   = '0;
                                n_acc   = '0;
                            end else if ((g_acc[31:0] & MAGIC_SKIP_MASK) == MAGIC_SKIP) begin
                                n_skippable = 1'b1;
                                n_dict      = g_acc[31:0] - MAGIC_SKIP;
                                n_phase     = PH_SKIPLEN;
                                n_idx       = '0;
                                n_acc       = '0;
                            end else begin
                                n_err   = ST_BAD_MAGIC;
                                n_phase = PH_ERROR;
                            end
                        end
                    end
                    PH_SKIPLEN: begin
                        n_acc = g_acc;
                        n_idx = g_idx;
                        if (g_idx == 4'd4) begin
                            if (g_acc[31:0] > SKIP_LEN_MAX) begin
                                n_err   = ST_SKIP_OVERFLOW;
                                n_phase = PH_ERROR;
                            end else if (g_acc[31:0] == 32'd0) begin
                                fin = 1'b1;
                            end else begin
                                n_skip  = g_acc[31:0];
                                n_phase = PH_SKIPBODY;
                            end
                        end
                    end
                    PH_SKIPBODY, PH_CHECKSUM: begin
                        n_skip = r_skip - 32'd1;
                        fin    = (n_skip == 32'd0);
                    end
                    PH_DESC: begin
                        n_desc = i_item.data_byte;
                        if ((i_item.data_byte & DESC_RESERVED) != 8'd0) begin
                            n_err   = ST_RESERVED_BIT;
                            n_phase = PH_ERROR;
                        end else if (!i_item.data_byte[5]) begin
                            n_phase = PH_WINDOW;
                        end else begin
                            n_phase = after_desc(i_item.data_byte);
                            n_idx   = '0;
                            n_acc   = '0;
                        end
                    end
                    PH_WINDOW: begin
                        if ({3'b000, i_item.data_byte[7:3]} + WLOG_BASE > WLOG_MAX) begin
                            n_err   = ST_WINDOW_LOG;
                            n_phase = PH_ERROR;
                        end else begin
                            n_phase = after_desc(r_desc);
                            n_idx   = '0;
                            n_acc   = '0;
                        end
                    end
                    PH_DICT: begin
                        n_acc = g_acc;
                        n_idx = g_idx;
                        if (g_idx >= DICT_LEN_TAB[r_desc[1:0]]) begin
                            n_dict  = g_acc[31:0];
                            n_phase = after_dict(r_desc);
                            n_idx   = '0;
                            n_acc   = '0;
                        end
                    end
                    PH_FCS: begin
                        n_acc = g_acc;
                        n_idx = g_idx;
                        if (g_idx >= fcs_len(r_desc)) begin
                            // A two-byte size field is stored with an offset.
                            n_csize = (r_desc[7:6] == 2'd1) ? g_acc + FCS_OFFSET : g_acc;
                            n_phase = PH_BLKHDR;
                            n_idx   = '0;
                            n_acc   = '0;
                        end
                    end
                    PH_BLKHDR: begin
                        n_acc = g_acc;
                        n_idx = g_idx;
                        if (g_idx == 4'd3) begin
                            if (blk_hdr[2:1] == BT_FORBIDDEN) begin
                                n_err   = ST_RESERVED_BLOCK;
                                n_phase = PH_ERROR;
                            end else begin
                                n_last_blk = blk_hdr[0];
                                if (blk_size == 32'd0) begin
                                    blk_done = 1'b1;
                                end else begin
                                    n_skip  = blk_size;
                                    n_phase = PH_BLKBODY;
                                end
                            end
                        end
                    end
                    PH_BLKBODY: begin
                        n_skip   = r_skip - 32'd1;
                        blk_done = (n_skip == 32'd0);
                    end
                    default: begin
                        n_err   = ST_TRUNCATED;
                        n_phase = PH_ERROR;
                    end
                endcase

                if (blk_done) begin
                    if (!n_last_blk) begin
                        n_phase = PH_BLKHDR;
                        n_idx   = '0;
                        n_acc   = '0;
                    end else if (r_desc[2]) begin
                        n_skip  = CHECKSUM_LEN;
                        n_phase = PH_CHECKSUM;
                    end else begin
                        fin = 1'b1;
                    end
                end

                if (fin) begin
                    if (!r_skippable && !known && i_mode) begin
                        n_err   = ST_SIZE_UNKNOWN;
                        n_phase = PH_ERROR;
                    end else begin
                        // The new count is compared as r_count >= r_lf.
                        if (r_count >= r_lf) begin
                            n_lf = cnt_inc;
                        end
                        if (!r_skippable && known && r_csize > r_lc) begin
                            n_lc = r_csize;
                        end
                        emit.num    = 2'd1;
                        emit.res0   = res_frame;
                        n_phase     = PH_MAGIC;
                        n_idx       = '0;
                        n_acc       = '0;
                        n_desc      = '0;
                        n_skip      = '0;
                        n_count     = '0;
                        n_csize     = '1;
                        n_dict      = '0;
                        n_skippable = 1'b0;
                        n_last_blk  = 1'b0;
                    end
                end
            end
        end

        best_zero = i_mode ? (n_lc == '0) : (n_lf == '0);
        st        = n_err;
        if (st == ST_OK && !(n_phase == PH_MAGIC && n_idx == 4'd0)) begin
            st = ST_TRUNCATED;
        end
        if (st == ST_OK && best_zero) begin
            st = ST_NONE_FOUND;
        end
        res_sum                      = '0;
        res_sum.result_kind          = 1'b1;
        res_sum.largest_frame_size   = (st != ST_OK) ? '0 : FSIZE_W'(n_lf);
        res_sum.largest_content_size = (st != ST_OK) ? '0 : n_lc;
        res_sum.status               = st;
        res_sum.last_result          = 1'b1;

        if (i_take && i_item.last_of_stream) begin
            if (emit.num == 2'd1) begin
                emit.res1 = res_sum;
            end else begin
                emit.res0 = res_sum;
            end
            emit.num    = emit.num + 2'd1;
            n_phase     = PH_MAGIC;
            n_idx       = '0;
            n_acc       = '0;
            n_desc      = '0;
            n_skip      = '0;
            n_count     = '0;
            n_csize     = '1;
            n_dict      = '0;
            n_skippable = 1'b0;
            n_last_blk  = 1'b0;
            n_lf        = '0;
            n_lc        = '0;
            n_err       = ST_OK;
        end
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_idx       <= '0;
            r_acc       <= '0;
            r_desc      <= '0;
            r_skip      <= '0;
            r_count     <= '0;
            r_csize     <= '1;
            r_dict      <= '0;
            r_skippable <= 1'b0;
            r_last_blk  <= 1'b0;
            r_lf        <= '0;
            r_lc        <= '0;
            r_err       <= ST_OK;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_acc       <= n_acc;
            r_desc      <= n_desc;
            r_skip      <= n_skip;
            r_count     <= n_count;
            r_csize     <= n_csize;
            r_dict      <= n_dict;
            r_skippable <= n_skippable;
            r_last_blk  <= n_last_blk;
            r_lf        <= n_lf;
            r_lc        <= n_lc;
            r_err       <= n_err;
        end
    end

endmodule

// File: hw/rtl/zfs_rqueue.sv
// Result queue: takes up to two results a cycle from the parser and hands
// them out one per transaction.
// Depends on zfs_pkg.
`timescale 1ns / 1ps

module zfs_rqueue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  zfs_pkg::t_emit   i_push,
    input  logic             i_pop,
    output logic             o_valid,
    output zfs_pkg::t_result o_head,
    output logic             o_room2
);
    import zfs_pkg::*;

    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    t_result            r_mem [RQ_DEPTH];
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_head];
    assign o_room2 = (r_cnt <= CNT_W'(RQ_DEPTH - 2));
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_head = r_head + PTR_W'(pop);
        n_tail = r_tail + PTR_W'(i_push.num);
        n_cnt  = r_cnt + CNT_W'(i_push.num) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_tail] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_tail + PTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// File: hw/rtl/zstd_frame_size_scanner_core.sv
// Frame size scanner: one stream byte per cycle unless stalled, a registered
// input stage, the header parser and a four-entry result queue. A result can
// first be taken once it has passed the input register and the queue. One input
// transaction is accepted per cycle while the queue has room for two results;
// an item that ends a frame and the stream takes two output transactions.
// Reset is synchronous and active low; it clears the stream state and mode.
`timescale 1ns / 1ps

module zstd_frame_size_scanner_core #(
    parameter int FRAME_SIZE_BITS = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    zfs_in_if.sink    i_in,
    zfs_cfg_if.sink   i_cfg,
    zfs_out_if.source o_out
);
    import zfs_pkg::*;

    logic    r_in_vld;
    t_item   r_item;
    logic    r_mode;
    logic    room2;
    logic    take;
    logic    in_acc;
    t_emit   emit;
    t_result head;
    logic    head_vld;

    assign take       = r_in_vld && room2;
    assign i_in.ready = !r_in_vld || room2;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (take) begin
                r_in_vld <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_mode <= i_cfg.content_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.data_byte      <= i_in.data_byte;
            r_item.has_byte       <= i_in.has_byte;
            r_item.last_of_stream <= i_in.last_of_stream;
        end
    end

    zfs_parser #(
        .FRAME_SIZE_BITS(FRAME_SIZE_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (r_item),
        .i_mode  (r_mode),
        .o_emit  (emit)
    );

    zfs_rqueue u_rqueue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_pop   (o_out.ready),
        .o_valid (head_vld),
        .o_head  (head),
        .o_room2 (room2)
    );

    assign o_out.valid                = head_vld;
    assign o_out.result_kind          = head.result_kind;
    assign o_out.frame_size           = head.frame_size;
    assign o_out.frame_skippable      = head.frame_skippable;
    assign o_out.dictionary_id        = head.dictionary_id;
    assign o_out.content_size         = head.content_size;
    assign o_out.content_known        = head.content_known;
    assign o_out.largest_frame_size   = head.largest_frame_size;
    assign o_out.largest_content_size = head.largest_content_size;
    assign o_out.status               = head.status;
    assign o_out.last_result          = head.last_result;

endmodule
